// ===== rtl/core/cached_nearest_palette_color_core_assert.svh =====
// Assertion macros shared by the nearest palette color core.
`ifndef CACHED_NEAREST_PALETTE_COLOR_CORE_ASSERT_SVH
`define CACHED_NEAREST_PALETTE_COLOR_CORE_ASSERT_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define NPC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define NPC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/core/cnpc_pkg.sv =====
// Shared types and constants of the nearest palette color core.
package cnpc_pkg;
    localparam int CacheEntriesDefault = 32;
    localparam logic [1:0] ModeWrite      = 2'd0;
    localparam logic [1:0] ModeInvalidate = 2'd1;
    localparam logic [1:0] ModeQuery      = 2'd2;
    localparam logic [1:0] ModeUnused     = 2'd3;
    localparam logic [7:0] FirstCandidate = 8'd255;
    localparam logic [7:0] ScanEnd        = 8'd254;
    localparam logic [7:0] SwapAbove      = 8'd4;

    typedef struct packed {
        logic load;          // latch the input item
        logic write_pal;     // write the palette entry
        logic invalidate;    // clear all valid marks
        logic cache_start;   // start cache scan at slot 0
        logic cache_step;    // advance cache scan
        logic swap;          // swap hit slot with the one below if above slot 4
        logic pal_start;     // start palette read of candidate 255
        logic pal_step;      // evaluate read data, read next entry
        logic cache_add;     // store the miss answer in the cache
        logic out_load;      // load the output register
    } cnpc_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       cache_done;  // scan reached the fill limit
        logic       cache_hit;   // current slot matches
        logic       pal_done;    // search finished
    } cnpc_sts_t;
endpackage

// ===== rtl/core/cnpc_datapath.sv =====
// Datapath: palette memory, cache, distance unit and output register.
`include "cached_nearest_palette_color_core_assert.svh"
module cnpc_datapath #(
    parameter int CACHE_ENTRIES = cnpc_pkg::CacheEntriesDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cnpc_pkg::cnpc_cmd_t cmd,
    output cnpc_pkg::cnpc_sts_t sts,
    input  logic [1:0]         s_mode,
    input  logic [7:0]         s_entry_index,
    input  logic [5:0]         s_red,
    input  logic [5:0]         s_green,
    input  logic [5:0]         s_blue,
    input  logic [4:0]         s_victim_slot,
    output logic [7:0]         out_color,
    output logic               out_hit
);
    localparam int SW = $clog2(CACHE_ENTRIES);
    localparam int FW = $clog2(CACHE_ENTRIES + 1);

    logic [17:0] pal_mem [256];
    logic [17:0] pal_rd_reg;
    logic [25:0] cache_mem_reg [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] valid_reg;
    logic [FW-1:0] fill_reg;
    logic [1:0]  mode_reg;
    logic [7:0]  idx_reg;
    logic [17:0] rgb_reg;
    logic [4:0]  victim_reg;
    logic [FW-1:0] slot_reg;    // wide enough that the scan can reach a full cache's end
    logic [7:0]  rd_addr_reg;   // address whose data sits in pal_rd_reg, unless first_reg
    logic [7:0]  best_idx_reg;
    logic [13:0] best_reg;
    logic        first_reg;     // pal_rd_reg holds candidate 255
    logic        pal_done_reg;
    logic [7:0]  color_reg;
    logic        hit_reg;

    logic [6:0]  dr, dg, db;
    logic [13:0] sq_dist;
    logic        slot_hit;
    logic [FW-1:0] slot_ext;
    logic [SW-1:0] slot_idx;
    logic [SW-1:0] victim_slot;

    // The victim is below 32 and the cache holds at least 8 slots, so three
    // conditional subtractions reduce it modulo the cache size.
    function automatic logic [SW-1:0] victim_mod(logic [4:0] v);
        logic [8:0] r;
        r = {4'b0000, v};
        for (int k = 0; k < 3; k++) begin
            if (r >= 9'(CACHE_ENTRIES)) begin
                r = r - 9'(CACHE_ENTRIES);
            end
        end
        return r[SW-1:0];
    endfunction

    assign dr = {1'b0, rgb_reg[17:12]} - {1'b0, pal_rd_reg[17:12]};
    assign dg = {1'b0, rgb_reg[11:6]}  - {1'b0, pal_rd_reg[11:6]};
    assign db = {1'b0, rgb_reg[5:0]}   - {1'b0, pal_rd_reg[5:0]};
    assign sq_dist = 14'($signed(dr) * $signed(dr)) + 14'($signed(dg) * $signed(dg))
                   + 14'($signed(db) * $signed(db));

    assign slot_ext = slot_reg;
    assign slot_idx = slot_reg[SW-1:0];
    assign slot_hit = valid_reg[slot_idx] && (cache_mem_reg[slot_idx][25:8] == rgb_reg);
    assign victim_slot = victim_mod(victim_reg);

    assign sts.mode       = mode_reg;
    assign sts.cache_hit  = slot_hit;
    assign sts.cache_done = (slot_ext >= fill_reg) || (FW'(CACHE_ENTRIES) == slot_ext);
    assign sts.pal_done   = pal_done_reg;

    // Palette memory: one write or one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.write_pal) begin
            pal_mem[idx_reg] <= rgb_reg;
        end
        if (cmd.pal_start) begin
            pal_rd_reg <= pal_mem[cnpc_pkg::FirstCandidate];
        end else if (cmd.pal_step) begin
            pal_rd_reg <= pal_mem[rd_addr_reg + 8'd1];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg   <= s_mode;
            idx_reg    <= s_entry_index;
            rgb_reg    <= {s_red, s_green, s_blue};
            victim_reg <= s_victim_slot;
        end
        if (cmd.cache_start) begin
            slot_reg <= '0;
        end else if (cmd.cache_step) begin
            slot_reg <= slot_reg + FW'(1);
        end
        if (cmd.swap && (8'(slot_reg) > cnpc_pkg::SwapAbove)) begin
            cache_mem_reg[slot_idx - SW'(1)] <= cache_mem_reg[slot_idx];
            cache_mem_reg[slot_idx] <= cache_mem_reg[slot_idx - SW'(1)];
        end else if (cmd.cache_add) begin
            if (fill_reg < FW'(CACHE_ENTRIES)) begin
                cache_mem_reg[fill_reg[SW-1:0]] <= {rgb_reg, best_idx_reg};
            end else begin
                cache_mem_reg[victim_slot] <= {rgb_reg, best_idx_reg};
            end
        end
        if (cmd.pal_start) begin
            rd_addr_reg <= 8'd0;
            first_reg   <= 1'b1;
        end else if (cmd.pal_step) begin
            rd_addr_reg <= rd_addr_reg + 8'd1;
            first_reg   <= 1'b0;
            if (first_reg) begin
                best_reg     <= sq_dist;
                best_idx_reg <= cnpc_pkg::FirstCandidate;
            end else if (sq_dist < best_reg) begin
                best_reg     <= sq_dist;
                best_idx_reg <= rd_addr_reg;
            end
        end
        if (cmd.out_load) begin
            color_reg <= cmd.cache_add ? best_idx_reg : cache_mem_reg[slot_idx][7:0];
            hit_reg   <= !cmd.cache_add;
        end
    end

    // Control state of the cache and the search.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            fill_reg     <= '0;
            pal_done_reg <= 1'b0;
        end else begin
            if (cmd.invalidate) begin
                valid_reg <= '0;
            end else if (cmd.swap && (8'(slot_reg) > cnpc_pkg::SwapAbove)) begin
                valid_reg[slot_idx - SW'(1)] <= valid_reg[slot_idx];
                valid_reg[slot_idx] <= valid_reg[slot_idx - SW'(1)];
            end else if (cmd.cache_add) begin
                if (fill_reg < FW'(CACHE_ENTRIES)) begin
                    valid_reg[fill_reg[SW-1:0]] <= 1'b1;
                    fill_reg <= fill_reg + FW'(1);
                end else begin
                    valid_reg[victim_slot] <= 1'b1;
                end
            end
            if (cmd.pal_start || cmd.cache_add) begin
                pal_done_reg <= 1'b0;
            end else if (cmd.pal_step) begin
                // Data of candidate 255 is evaluated first, then 1..253.
                if (first_reg) begin
                    pal_done_reg <= (sq_dist == 14'd0);
                end else if (rd_addr_reg != 8'd0) begin
                    pal_done_reg <= ((sq_dist < best_reg) && (sq_dist == 14'd0))
                                  || (rd_addr_reg == cnpc_pkg::ScanEnd - 8'd1);
                end
            end
        end
    end

    assign out_color = color_reg;
    assign out_hit   = hit_reg;

    // A fill count never exceeds the cache size.
    `NPC_ASSERT_IMP(a_fill_range, aclk, aresetn, 1'b1, fill_reg <= FW'(CACHE_ENTRIES), "fill overflow")
    // A swap and an append never coincide.
    `NPC_ASSERT_IMP(a_swap_add, aclk, aresetn, cmd.swap, !cmd.cache_add, "swap with add")
    // Invalidate leaves no valid mark behind.
    `NPC_ASSERT_NEXT(a_inv, aclk, aresetn, cmd.invalidate, valid_reg == '0, "valid after invalidate")
endmodule

// ===== rtl/core/cnpc_ctrl.sv =====
// Controller state machine of the nearest palette color core.
`include "cached_nearest_palette_color_core_assert.svh"
module cnpc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  cnpc_pkg::cnpc_sts_t sts,
    output cnpc_pkg::cnpc_cmd_t cmd
);
    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StDisp  = 3'd1;
    localparam logic [2:0] StCache = 3'd2;
    localparam logic [2:0] StPal   = 3'd3;
    localparam logic [2:0] StOut   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;
    logic       out_free;

    assign out_free = !mvalid_reg || m_ready;
    assign s_ready  = (state_reg == StIdle);
    assign m_valid  = mvalid_reg;

    always_comb begin
        cmd         = '0;
        state_next  = state_reg;
        mvalid_next = mvalid_reg && !m_ready;
        unique case (state_reg)
            StIdle: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = StDisp;
                end
            end
            StDisp: begin
                cmd.cache_start = 1'b1;
                unique case (sts.mode)
                    cnpc_pkg::ModeWrite: begin
                        cmd.write_pal = 1'b1;
                        state_next = StIdle;
                    end
                    cnpc_pkg::ModeInvalidate: begin
                        cmd.invalidate = 1'b1;
                        state_next = StIdle;
                    end
                    cnpc_pkg::ModeQuery: state_next = StCache;
                    default: state_next = StIdle;
                endcase
            end
            StCache: begin
                if (sts.cache_done) begin
                    cmd.pal_start = 1'b1;
                    state_next = StPal;
                end else if (sts.cache_hit) begin
                    if (out_free) begin
                        cmd.swap     = 1'b1;
                        cmd.out_load = 1'b1;
                        mvalid_next  = 1'b1;
                        state_next   = StIdle;
                    end
                end else begin
                    cmd.cache_step = 1'b1;
                end
            end
            StPal: begin
                if (sts.pal_done) begin
                    state_next = StOut;
                end else begin
                    cmd.pal_step = 1'b1;
                end
            end
            StOut: begin
                if (out_free) begin
                    cmd.cache_add = 1'b1;
                    cmd.out_load  = 1'b1;
                    mvalid_next   = 1'b1;
                    state_next    = StIdle;
                end
            end
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= StIdle;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // A result is only loaded when the output register is free.
    `NPC_ASSERT_IMP(a_out_free, aclk, aresetn, cmd.out_load, out_free, "output overrun")
    // Palette steps only happen in the search state.
    `NPC_ASSERT_IMP(a_step_st, aclk, aresetn, cmd.pal_step, state_reg == StPal, "stray step")
    // A loaded result is offered in the next cycle.
    `NPC_ASSERT_NEXT(a_out_v, aclk, aresetn, cmd.out_load, m_valid, "result not offered")
endmodule

// ===== rtl/core/cached_nearest_palette_color_core.sv =====
// Top level of the cached nearest palette color core.
// Usage: one input channel (s_valid/s_ready) carries items with a mode: write a
// palette entry, invalidate the answer cache, or query the nearest palette color.
// Only a query gives a result item on the m_ channel, with the palette index and
// a flag that tells whether the answer came from the cache.
// Items are handled one at a time. A write or invalidate is done in the dispatch state.
// A query scans the cache one slot per cycle up to the fill count; a hit
// loads the result from that slot when the output register is free. A miss then
// walks the palette through its single read port, one entry per cycle,
// candidate 255 then 1..253, stopping on an exact match, and loads its result
// when the output register is free.
// The result sits in an output register. While the receiver stalls, the next
// item is still taken and worked on, but a query result waits until the output
// register is free, and no further item is taken meanwhile.
// Reset clears the cache valid marks, the fill count and the handshake state.
// Palette contents are undefined until written; queries must only touch
// written entries.
module cached_nearest_palette_color_core #(
    parameter int CACHE_ENTRIES = cnpc_pkg::CacheEntriesDefault
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_entry_index,
    input  logic [5:0] s_red,
    input  logic [5:0] s_green,
    input  logic [5:0] s_blue,
    input  logic [4:0] s_victim_slot,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_color_index,
    output logic       m_cache_hit
);
    cnpc_pkg::cnpc_cmd_t cmd;
    cnpc_pkg::cnpc_sts_t sts;

    // The controller sequences cache scan, palette search and output handshake.
    cnpc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    // The datapath holds all storage and the distance unit.
    cnpc_datapath #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .s_mode(s_mode), .s_entry_index(s_entry_index), .s_red(s_red),
        .s_green(s_green), .s_blue(s_blue), .s_victim_slot(s_victim_slot),
        .out_color(m_color_index), .out_hit(m_cache_hit)
    );
endmodule
